[rtl/stdp_pkg.sv]
// Shared types, constants and the control program of the stepper delay profile unit.
package stdp_pkg;

    localparam int unsigned STEPS_PER_REV_DEF = 64;

    localparam int unsigned FIELD_W     = 16;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned DIV_W       = 32;
    localparam int unsigned CNT_W       = 6;

    localparam logic [FIELD_W-1:0] DELAY_NUM     = 16'd60000;
    localparam logic [FIELD_W-1:0] MIN_DELAY_RST = 16'd5;
    localparam logic [FIELD_W-1:0] MAX_DELAY_RST = 16'd500;

    localparam logic [CNT_W-1:0] DIV_CNT_START = 6'd16;
    localparam logic [CNT_W-1:0] DIV_CNT_STEP  = 6'd32;

    localparam logic CFG_MIN_DELAY = 1'b0;
    localparam logic CFG_MAX_DELAY = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        A_NOP,
        A_LATCH,
        A_MUL_RPM,
        A_DIV_START,
        A_DIV_STEP,
        A_START,
        A_REJECT,
        A_PHASE,
        A_MUL_SPAN,
        A_DIV_STEPLD,
        A_STEP_FIN,
        A_RES_CLR,
        A_EMIT
    } t_act;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_OP_NEXT,
        C_CNT_ZERO,
        C_RPM_ZERO,
        C_INACTIVE,
        C_DIV_LAST,
        C_OUT_FREE
    } t_cond;

    typedef logic [3:0] t_addr;

    localparam t_addr ADDR_IDLE     = 4'd0;
    localparam t_addr ADDR_DISPATCH = 4'd1;
    localparam t_addr ADDR_CHK_CNT  = 4'd2;
    localparam t_addr ADDR_MUL_RPM  = 4'd3;
    localparam t_addr ADDR_DIV_LD_S = 4'd4;
    localparam t_addr ADDR_DIV_RUN0 = 4'd5;
    localparam t_addr ADDR_START    = 4'd6;
    localparam t_addr ADDR_REJECT   = 4'd7;
    localparam t_addr ADDR_PHASE    = 4'd8;
    localparam t_addr ADDR_MUL_SPAN = 4'd9;
    localparam t_addr ADDR_DIV_LD_N = 4'd10;
    localparam t_addr ADDR_DIV_RUN1 = 4'd11;
    localparam t_addr ADDR_STEP_FIN = 4'd12;
    localparam t_addr ADDR_RES_CLR  = 4'd13;
    localparam t_addr ADDR_EMIT     = 4'd14;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_addr target;
        logic  hold;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic op_next;
        logic cnt_zero;
        logic rpm_zero;
        logic inactive;
        logic div_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [CNT_W-1:0] count;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_cmd;

    // Control store: when the condition holds the step jumps to its target, otherwise it
    // either stays (hold) or moves on to the next address.
    function automatic t_ctrl ucode(input t_addr a);
        t_ctrl w;
        unique case (a)
            ADDR_IDLE:     w = '{A_LATCH,      C_IN_VALID, ADDR_DISPATCH, 1'b1};
            ADDR_DISPATCH: w = '{A_NOP,        C_OP_NEXT,  ADDR_PHASE,    1'b0};
            ADDR_CHK_CNT:  w = '{A_NOP,        C_CNT_ZERO, ADDR_REJECT,   1'b0};
            ADDR_MUL_RPM:  w = '{A_MUL_RPM,    C_RPM_ZERO, ADDR_START,    1'b0};
            ADDR_DIV_LD_S: w = '{A_DIV_START,  C_ALWAYS,   ADDR_DIV_RUN0, 1'b0};
            ADDR_DIV_RUN0: w = '{A_DIV_STEP,   C_DIV_LAST, ADDR_START,    1'b1};
            ADDR_START:    w = '{A_START,      C_ALWAYS,   ADDR_EMIT,     1'b0};
            ADDR_REJECT:   w = '{A_REJECT,     C_ALWAYS,   ADDR_EMIT,     1'b0};
            ADDR_PHASE:    w = '{A_PHASE,      C_INACTIVE, ADDR_RES_CLR,  1'b0};
            ADDR_MUL_SPAN: w = '{A_MUL_SPAN,   C_ALWAYS,   ADDR_DIV_LD_N, 1'b0};
            ADDR_DIV_LD_N: w = '{A_DIV_STEPLD, C_ALWAYS,   ADDR_DIV_RUN1, 1'b0};
            ADDR_DIV_RUN1: w = '{A_DIV_STEP,   C_DIV_LAST, ADDR_STEP_FIN, 1'b1};
            ADDR_STEP_FIN: w = '{A_STEP_FIN,   C_ALWAYS,   ADDR_EMIT,     1'b0};
            ADDR_RES_CLR:  w = '{A_RES_CLR,    C_ALWAYS,   ADDR_EMIT,     1'b0};
            ADDR_EMIT:     w = '{A_EMIT,       C_OUT_FREE, ADDR_IDLE,     1'b1};
            default:       w = '{A_NOP,        C_ALWAYS,   ADDR_IDLE,     1'b0};
        endcase
        return w;
    endfunction

endpackage

[rtl/stdp_divider.sv]
// Shared restoring divider producing one quotient bit per cycle.
module stdp_divider import stdp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_cmd         i_cmd,
    output logic [DIV_W-1:0] o_quotient,
    output logic             o_last
);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvsr;
    logic [CNT_W-1:0] r_cnt;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvsr};
        ge      = ~diff[DIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= i_cmd.count;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= '0;
            r_quo  <= i_cmd.dividend;
            r_dvsr <= i_cmd.divisor;
        end else if (i_cmd.step) begin
            r_rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = (r_cnt == CNT_W'(1));

endmodule

[rtl/stdp_sequencer.sv]
// Step counter and jump logic that walks the control store.
module stdp_sequencer import stdp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_addr r_pc;
    t_addr n_pc;
    t_ctrl ctrl;
    logic  taken;

    always_comb begin
        ctrl = ucode(r_pc);
        unique case (ctrl.cond)
            C_ALWAYS:   taken = 1'b1;
            C_IN_VALID: taken = i_status.in_valid;
            C_OP_NEXT:  taken = i_status.op_next;
            C_CNT_ZERO: taken = i_status.cnt_zero;
            C_RPM_ZERO: taken = i_status.rpm_zero;
            C_INACTIVE: taken = i_status.inactive;
            C_DIV_LAST: taken = i_status.div_last;
            C_OUT_FREE: taken = i_status.out_free;
            default:    taken = 1'b1;
        endcase
        if (taken) begin
            n_pc = ctrl.target;
        end else if (ctrl.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + t_addr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ADDR_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

[rtl/stdp_datapath.sv]
// Datapath: move state, multiplier, delay arithmetic and the result register.
module stdp_datapath import stdp_pkg::*; #(
    parameter int unsigned STEPS_PER_REV = STEPS_PER_REV_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl                  i_ctrl,
    output t_status                o_status,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [FIELD_W-1:0]     i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast,
    output t_div_cmd               o_div_cmd,
    input  logic [DIV_W-1:0]       i_quotient,
    input  logic                   i_div_last
);

    localparam logic [FIELD_W-1:0] SPR = FIELD_W'(STEPS_PER_REV);

    logic [FIELD_W-1:0] r_min;
    logic [FIELD_W-1:0] r_max;
    logic               r_active;
    logic               r_fwd;
    logic [FIELD_W-1:0] r_total;
    logic [FIELD_W-1:0] r_index;
    logic [FIELD_W-1:0] r_cruise;
    logic [FIELD_W-1:0] r_ramp;
    logic [FIELD_W-1:0] r_cruise_len;

    logic               r_op;
    logic [FIELD_W-1:0] r_cnt;
    logic [FIELD_W-1:0] r_rpm;
    logic [FIELD_W-1:0] r_acc;

    t_phase             r_ph;
    logic [FIELD_W-1:0] r_span;
    logic [FIELD_W-1:0] r_mop;
    logic [DIV_W-1:0]   r_prod;

    logic               r_res_step;
    logic               r_res_dir;
    logic [FIELD_W-1:0] r_res_delay;
    t_phase             r_res_ph;
    logic               r_res_last;
    logic               r_res_rej;

    logic               r_out_valid;
    logic               r_out_step;
    logic               r_out_dir;
    logic [FIELD_W-1:0] r_out_delay;
    t_phase             r_out_ph;
    logic               r_out_last;
    logic               r_out_rej;

    logic               accept;
    logic               out_free;

    logic [FIELD_W-1:0] ramp_end;
    logic [FIELD_W:0]   cruise_end;
    logic [FIELD_W:0]   jj_full;
    logic [FIELD_W-1:0] span;
    t_phase             ph;

    logic [FIELD_W-1:0] mul_a;
    logic [FIELD_W-1:0] mul_b;

    logic [FIELD_W-1:0] mag;
    logic [FIELD_W-1:0] s_ramp_end;
    logic [FIELD_W-1:0] rest;
    logic [FIELD_W-1:0] cruise_len;
    logic [FIELD_W-1:0] t_raw;
    logic [FIELD_W-1:0] t_lo;
    logic [FIELD_W-1:0] t_cl;

    logic [FIELD_W-1:0] d_acc0;
    logic [FIELD_W-1:0] d_acc;
    logic [DIV_W:0]     d_sum;
    logic [FIELD_W-1:0] d_dec;
    logic [FIELD_W-1:0] d_step;
    logic [FIELD_W:0]   next_index;
    logic               last;

    assign accept   = (i_ctrl.act == A_LATCH) && s_axis_tvalid;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        ramp_end   = (r_ramp < r_total) ? r_ramp : r_total;
        cruise_end = {1'b0, ramp_end} + {1'b0, r_cruise_len};
        jj_full    = {1'b0, r_index} - cruise_end;
        span       = (r_max > r_cruise) ? (r_max - r_cruise) : '0;
        if (r_index < ramp_end) begin
            ph = PH_ACCEL;
        end else if ({1'b0, r_index} < cruise_end) begin
            ph = PH_CRUISE;
        end else begin
            ph = PH_DECEL;
        end
    end

    always_comb begin
        if (i_ctrl.act == A_MUL_RPM) begin
            mul_a = r_rpm;
            mul_b = SPR;
        end else begin
            mul_a = r_span;
            mul_b = r_mop;
        end
    end

    always_comb begin
        o_div_cmd.load = (i_ctrl.act == A_DIV_START) || (i_ctrl.act == A_DIV_STEPLD);
        o_div_cmd.step = (i_ctrl.act == A_DIV_STEP);
        if (i_ctrl.act == A_DIV_START) begin
            o_div_cmd.count    = DIV_CNT_START;
            o_div_cmd.dividend = {DELAY_NUM, {(DIV_W-FIELD_W){1'b0}}};
            o_div_cmd.divisor  = r_prod;
        end else begin
            o_div_cmd.count    = DIV_CNT_STEP;
            o_div_cmd.dividend = r_prod;
            o_div_cmd.divisor  = {{(DIV_W-FIELD_W){1'b0}},
                                  ((r_ramp != '0) ? r_ramp : FIELD_W'(1))};
        end
    end

    always_comb begin
        mag        = r_cnt[FIELD_W-1] ? (~r_cnt + FIELD_W'(1)) : r_cnt;
        s_ramp_end = (r_acc < mag) ? r_acc : mag;
        rest       = mag - s_ramp_end;
        cruise_len = (rest > r_acc) ? (rest - r_acc) : '0;
        t_raw      = (r_rpm == '0) ? r_max : i_quotient[FIELD_W-1:0];
        t_lo       = (t_raw < r_min) ? r_min : t_raw;
        t_cl       = (t_lo > r_max) ? r_max : t_lo;
    end

    always_comb begin
        d_acc0     = r_max - i_quotient[FIELD_W-1:0];
        d_acc      = (d_acc0 < r_cruise) ? r_cruise : d_acc0;
        d_sum      = {{(DIV_W+1-FIELD_W){1'b0}}, r_cruise} + {1'b0, i_quotient};
        d_dec      = (d_sum > {{(DIV_W+1-FIELD_W){1'b0}}, r_max}) ? r_max
                                                                  : d_sum[FIELD_W-1:0];
        unique case (r_ph)
            PH_ACCEL:  d_step = d_acc;
            PH_CRUISE: d_step = r_cruise;
            PH_DECEL:  d_step = d_dec;
            default:   d_step = r_cruise;
        endcase
        next_index = {1'b0, r_index} + {{FIELD_W{1'b0}}, 1'b1};
        last       = (next_index >= {1'b0, r_total});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_DELAY_RST;
            r_max       <= MAX_DELAY_RST;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_MIN_DELAY: r_min <= i_cfg_data;
                    CFG_MAX_DELAY: r_max <= i_cfg_data;
                    default:       r_min <= r_min;
                endcase
            end
            if (i_ctrl.act == A_START) begin
                r_active <= 1'b1;
            end else if ((i_ctrl.act == A_STEP_FIN) && last) begin
                r_active <= 1'b0;
            end
            if ((i_ctrl.act == A_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= s_axis_tuser;
            r_cnt <= s_axis_tdata[FIELD_W-1:0];
            r_rpm <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
            r_acc <= s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
        end
        unique case (i_ctrl.act)
            A_MUL_RPM, A_MUL_SPAN: begin
                r_prod <= {{(DIV_W-FIELD_W){1'b0}}, mul_a} * {{(DIV_W-FIELD_W){1'b0}}, mul_b};
            end
            A_START: begin
                r_fwd        <= ~r_cnt[FIELD_W-1];
                r_total      <= mag;
                r_index      <= '0;
                r_ramp       <= r_acc;
                r_cruise     <= t_cl;
                r_cruise_len <= cruise_len;
                r_res_step   <= 1'b0;
                r_res_dir    <= 1'b0;
                r_res_delay  <= '0;
                r_res_ph     <= PH_ACCEL;
                r_res_last   <= 1'b0;
                r_res_rej    <= 1'b0;
            end
            A_REJECT: begin
                r_res_step  <= 1'b0;
                r_res_dir   <= 1'b0;
                r_res_delay <= '0;
                r_res_ph    <= PH_ACCEL;
                r_res_last  <= 1'b0;
                r_res_rej   <= 1'b1;
            end
            A_RES_CLR: begin
                r_res_step  <= 1'b0;
                r_res_dir   <= 1'b0;
                r_res_delay <= '0;
                r_res_ph    <= PH_ACCEL;
                r_res_last  <= 1'b0;
                r_res_rej   <= 1'b0;
            end
            A_PHASE: begin
                r_ph   <= ph;
                r_span <= span;
                r_mop  <= (ph == PH_DECEL) ? jj_full[FIELD_W-1:0] : r_index;
            end
            A_STEP_FIN: begin
                r_index     <= next_index[FIELD_W-1:0];
                r_res_step  <= 1'b1;
                r_res_dir   <= r_fwd;
                r_res_delay <= d_step;
                r_res_ph    <= r_ph;
                r_res_last  <= last;
                r_res_rej   <= 1'b0;
            end
            A_EMIT: begin
                if (out_free) begin
                    r_out_step  <= r_res_step;
                    r_out_dir   <= r_res_dir;
                    r_out_delay <= r_res_delay;
                    r_out_ph    <= r_res_ph;
                    r_out_last  <= r_res_last;
                    r_out_rej   <= r_res_rej;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.in_valid = s_axis_tvalid;
        o_status.op_next  = (r_op == OP_NEXT);
        o_status.cnt_zero = (r_cnt == '0);
        o_status.rpm_zero = (r_rpm == '0);
        o_status.inactive = ~r_active;
        o_status.div_last = i_div_last;
        o_status.out_free = out_free;
    end

    assign s_axis_tready = (i_ctrl.act == A_LATCH);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-FIELD_W-3){1'b0}}, r_out_ph, r_out_delay, r_out_dir};
    assign m_axis_tuser  = {r_out_rej, r_out_step};
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/stepper_trapezoid_delay_profile_unit.sv]
// Top level of the trapezoidal stepper delay profile unit.
//
//  channel  direction  handshake                 payload
//  s_axis   in         s_axis_tvalid/tready      tdata: step_count, speed_rpm, ramp_steps
//                                                tuser: operation
//  m_axis   out        m_axis_tvalid/tready      tdata: direction, delay_ms, phase
//                                                tuser: step_valid, start_rejected; tlast
//  cfg      in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// One word is worked on at a time. A start or a step word spends most of its time in the
// shared divider, which resolves one quotient bit per cycle (16 bits for the cruise delay,
// 32 for a ramp delay). A start at zero speed skips the divider, as do a rejected
// start and a step word with no move in progress. Reset is synchronous and leaves no
// move active. A new word is accepted while the previous result waits in the output
// register; the result is only held back if that register is still full when it is ready.
module stepper_trapezoid_delay_profile_unit import stdp_pkg::*; #(
    parameter int unsigned STEPS_PER_REV = STEPS_PER_REV_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [FIELD_W-1:0]     i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // step_count [15:0], speed_rpm [31:16], ramp_steps [47:32]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // direction [0], delay_ms [16:1], phase [18:17], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // step_valid [0], start_rejected [1]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_ctrl            ctrl;
    t_status          status;
    t_div_cmd         div_cmd;
    logic [DIV_W-1:0] quotient;
    logic             div_last;

    stdp_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    stdp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .o_quotient (quotient),
        .o_last     (div_last)
    );

    stdp_datapath #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_div_cmd     (div_cmd),
        .i_quotient    (quotient),
        .i_div_last    (div_last)
    );

endmodule
